/* sv/gptsc_pkg.sv */
// Shared constants, types and codes for the Gaussian prime tile sieve counter.
package gptsc_pkg;

    localparam int TILE_SPAN      = 256;
    localparam int EDGE_MARGIN    = 7;
    localparam int SIDE_SPAN      = TILE_SPAN + 1 + 2 * EDGE_MARGIN;
    localparam int SPLIT_CAPACITY = 1024;
    localparam int INERT_CAPACITY = 1024;
    localparam int PRIME_WIDTH    = 14;
    localparam int ROOT_WIDTH     = 13;
    localparam int COORD_WIDTH    = 32;
    localparam int COUNT_WIDTH    = 17;

    localparam int SPLIT_AW  = (SPLIT_CAPACITY > 1) ? $clog2(SPLIT_CAPACITY) : 1;
    localparam int INERT_AW  = (INERT_CAPACITY > 1) ? $clog2(INERT_CAPACITY) : 1;
    localparam int MAX_CAP   = (SPLIT_CAPACITY > INERT_CAPACITY) ? SPLIT_CAPACITY
                                                                  : INERT_CAPACITY;
    localparam int USED_W    = $clog2(MAX_CAP + 1);
    localparam int IDX_W     = $clog2(SIDE_SPAN);
    localparam int ROW_W     = $clog2(SIDE_SPAN);
    localparam int COL_W     = $clog2(SIDE_SPAN + (1 << PRIME_WIDTH));
    localparam int STEP_W    = $clog2(COORD_WIDTH);
    localparam int SPLIT_W   = ROOT_WIDTH + PRIME_WIDTH;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_COUNT = 2'd2;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam logic KIND_SPLIT = 1'b0;
    localparam logic KIND_INERT = 1'b1;

    typedef struct packed {
        logic [1:0]              cmd;
        logic                    prime_kind;
        logic [13:0]             prime_value;
        logic [12:0]             minus_one_root;
        logic signed [31:0]      tile_a_low;
        logic signed [31:0]      tile_b_low;
    } t_req;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0]  survivor_count;
        logic                    table_overflow;
    } t_rsp;

    typedef enum logic [1:0] {
        MOD_A,
        MOD_PROD,
        MOD_B
    } t_mod_sel;

    typedef enum logic [1:0] {
        RES_POS,
        RES_NEG,
        RES_ZERO
    } t_res_sel;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ROW_INIT,
        S_SPLIT_RD,
        S_SPLIT_LAT,
        S_SPLIT_CHK,
        S_S_AMOD,
        S_S_PSTART,
        S_S_PMOD,
        S_S_BSTART,
        S_S_BMOD,
        S_POS_INIT,
        S_POS_MARK,
        S_NEG_INIT,
        S_NEG_MARK,
        S_INERT_RD,
        S_INERT_LAT,
        S_INERT_CHK,
        S_I_AMOD,
        S_I_TEST,
        S_I_BMOD,
        S_ZERO_INIT,
        S_ZERO_MARK,
        S_SUM_INIT,
        S_SUM,
        S_DONE
    } t_state;

    typedef struct packed {
        logic     do_clear;
        logic     do_load;
        logic     tile_init;
        logic     row_init;
        logic     row_inc;
        logic     k_clear;
        logic     k_inc;
        logic     ent_split;
        logic     ent_inert;
        logic     mod_start;
        t_mod_sel mod_sel;
        logic     mark_init;
        t_res_sel res_sel;
        logic     mark_step;
        logic     sum_init;
        logic     sum_step;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic split_end;
        logic inert_end;
        logic p_zero;
        logic amod_zero;
        logic neg_same;
        logic mark_end;
        logic sum_end;
        logic row_last;
        logic mod_done;
        logic rsp_full;
    } t_dp_stat;

endpackage

/* sv/gptsc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module gptsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/gptsc_rem.sv */
// Bit-serial unsigned remainder unit: 32-bit dividend by a prime, one bit per cycle.
module gptsc_rem (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [gptsc_pkg::COORD_WIDTH-1:0]   i_dividend,
    input  logic [gptsc_pkg::PRIME_WIDTH-1:0]   i_divisor,
    output logic                                o_done,
    output logic [gptsc_pkg::PRIME_WIDTH-1:0]   o_rem
);
    import gptsc_pkg::*;

    logic [COORD_WIDTH-1:0] r_dvd;
    logic [PRIME_WIDTH-1:0] r_rem;
    logic [STEP_W-1:0]      r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic [PRIME_WIDTH:0]   n_trial;
    logic [PRIME_WIDTH-1:0] n_rem;

    always_comb begin
        n_trial = {r_rem, r_dvd[COORD_WIDTH-1]};
        if (n_trial >= {1'b0, i_divisor}) begin
            n_rem = PRIME_WIDTH'(n_trial - {1'b0, i_divisor});
        end else begin
            n_rem = n_trial[PRIME_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_dvd  <= i_dividend;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_dvd <= r_dvd << 1;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(COORD_WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* sv/gptsc_ctrl.sv */
// Sequencer for clear, load and tile count requests.
module gptsc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic [1:0]            i_cmd,
    input  gptsc_pkg::t_dp_stat   i_stat,
    output logic                  o_req_ready,
    output gptsc_pkg::t_dp_cmd    o_cmd
);
    import gptsc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid && i_cmd == CMD_COUNT) begin
                    n_state = S_ROW_INIT;
                end
            end
            S_ROW_INIT:  n_state = S_SPLIT_RD;
            S_SPLIT_RD:  n_state = i_stat.split_end ? S_INERT_RD : S_SPLIT_LAT;
            S_SPLIT_LAT: n_state = S_SPLIT_CHK;
            S_SPLIT_CHK: n_state = i_stat.p_zero ? S_SPLIT_RD : S_S_AMOD;
            S_S_AMOD:    n_state = i_stat.mod_done ? S_S_PSTART : S_S_AMOD;
            S_S_PSTART:  n_state = S_S_PMOD;
            S_S_PMOD:    n_state = i_stat.mod_done ? S_S_BSTART : S_S_PMOD;
            S_S_BSTART:  n_state = S_S_BMOD;
            S_S_BMOD:    n_state = i_stat.mod_done ? S_POS_INIT : S_S_BMOD;
            S_POS_INIT:  n_state = S_POS_MARK;
            S_POS_MARK: begin
                if (i_stat.mark_end) begin
                    n_state = i_stat.neg_same ? S_SPLIT_RD : S_NEG_INIT;
                end
            end
            S_NEG_INIT:  n_state = S_NEG_MARK;
            S_NEG_MARK:  n_state = i_stat.mark_end ? S_SPLIT_RD : S_NEG_MARK;
            S_INERT_RD:  n_state = i_stat.inert_end ? S_SUM_INIT : S_INERT_LAT;
            S_INERT_LAT: n_state = S_INERT_CHK;
            S_INERT_CHK: n_state = i_stat.p_zero ? S_INERT_RD : S_I_AMOD;
            S_I_AMOD:    n_state = i_stat.mod_done ? S_I_TEST : S_I_AMOD;
            S_I_TEST:    n_state = i_stat.amod_zero ? S_I_BMOD : S_INERT_RD;
            S_I_BMOD:    n_state = i_stat.mod_done ? S_ZERO_INIT : S_I_BMOD;
            S_ZERO_INIT: n_state = S_ZERO_MARK;
            S_ZERO_MARK: n_state = i_stat.mark_end ? S_INERT_RD : S_ZERO_MARK;
            S_SUM_INIT:  n_state = S_SUM;
            S_SUM: begin
                if (i_stat.sum_end) begin
                    n_state = i_stat.row_last ? S_DONE : S_ROW_INIT;
                end
            end
            S_DONE:      n_state = i_stat.rsp_full ? S_DONE : S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    unique case (i_cmd)
                        CMD_CLEAR: o_cmd.do_clear  = 1'b1;
                        CMD_LOAD:  o_cmd.do_load   = 1'b1;
                        CMD_COUNT: o_cmd.tile_init = 1'b1;
                        default:   o_cmd.do_clear  = 1'b0;
                    endcase
                end
            end
            S_ROW_INIT: o_cmd.row_init = 1'b1;
            S_SPLIT_RD: o_cmd.k_clear  = i_stat.split_end;
            S_SPLIT_LAT: o_cmd.ent_split = 1'b1;
            S_SPLIT_CHK, S_INERT_CHK: begin
                if (i_stat.p_zero) begin
                    o_cmd.k_inc = 1'b1;
                end else begin
                    o_cmd.mod_start = 1'b1;
                    o_cmd.mod_sel   = MOD_A;
                end
            end
            S_S_PSTART: begin
                o_cmd.mod_start = 1'b1;
                o_cmd.mod_sel   = MOD_PROD;
            end
            S_S_BSTART: begin
                o_cmd.mod_start = 1'b1;
                o_cmd.mod_sel   = MOD_B;
            end
            S_POS_INIT: begin
                o_cmd.mark_init = 1'b1;
                o_cmd.res_sel   = RES_POS;
            end
            S_POS_MARK: begin
                if (!i_stat.mark_end) begin
                    o_cmd.mark_step = 1'b1;
                end else begin
                    o_cmd.k_inc = i_stat.neg_same;
                end
            end
            S_NEG_INIT: begin
                o_cmd.mark_init = 1'b1;
                o_cmd.res_sel   = RES_NEG;
            end
            S_NEG_MARK, S_ZERO_MARK: begin
                if (!i_stat.mark_end) begin
                    o_cmd.mark_step = 1'b1;
                end else begin
                    o_cmd.k_inc = 1'b1;
                end
            end
            S_INERT_LAT: o_cmd.ent_inert = 1'b1;
            S_I_TEST: begin
                if (i_stat.amod_zero) begin
                    o_cmd.mod_start = 1'b1;
                    o_cmd.mod_sel   = MOD_B;
                end else begin
                    o_cmd.k_inc = 1'b1;
                end
            end
            S_ZERO_INIT: begin
                o_cmd.mark_init = 1'b1;
                o_cmd.res_sel   = RES_ZERO;
            end
            S_SUM_INIT: o_cmd.sum_init = 1'b1;
            S_SUM: begin
                o_cmd.sum_step = 1'b1;
                o_cmd.row_inc  = i_stat.sum_end && !i_stat.row_last;
            end
            S_DONE: o_cmd.out_load = !i_stat.rsp_full;
            S_S_AMOD, S_S_PMOD, S_S_BMOD, S_INERT_RD, S_I_AMOD, S_I_BMOD: begin
                o_cmd = '0;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

/* sv/gptsc_dp.sv */
// Datapath: prime tables, residue unit, row marks, survivor total and result register.
module gptsc_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  gptsc_pkg::t_req       i_req,
    input  gptsc_pkg::t_dp_cmd    i_cmd,
    input  logic                  i_rsp_ready,
    output gptsc_pkg::t_dp_stat   o_stat,
    output logic                  o_rsp_valid,
    output gptsc_pkg::t_rsp       o_rsp
);
    import gptsc_pkg::*;

    logic [USED_W-1:0]      r_s_used;
    logic [USED_W-1:0]      r_i_used;
    logic                   r_ovf;
    logic [USED_W-1:0]      r_k;
    logic [COORD_WIDTH-1:0] r_a;
    logic [COORD_WIDTH-1:0] r_b0;
    logic [ROW_W-1:0]       r_row;
    logic [PRIME_WIDTH-1:0] r_p;
    logic [ROOT_WIDTH-1:0]  r_root;
    logic [PRIME_WIDTH-1:0] r_amod;
    logic [PRIME_WIDTH-1:0] r_res;
    logic [PRIME_WIDTH-1:0] r_bmod;
    t_mod_sel               r_sel;
    logic                   r_neg;
    logic [COL_W-1:0]       r_col;
    logic [SIDE_SPAN-1:0]   r_marks;
    logic [COUNT_WIDTH-1:0] r_total;
    logic                   r_rsp_valid;
    t_rsp                   r_rsp;

    logic                   s_we;
    logic                   i_we;
    logic [SPLIT_W-1:0]     s_rdata;
    logic [PRIME_WIDTH-1:0] i_rdata;
    logic                   rem_done;
    logic [PRIME_WIDTH-1:0] rem_val;

    logic [COORD_WIDTH-1:0] n_src;
    logic                   n_neg;
    logic [COORD_WIDTH-1:0] n_mag;
    logic [PRIME_WIDTH-1:0] n_fixed;
    logic [PRIME_WIDTH-1:0] n_negres;
    logic [PRIME_WIDTH-1:0] n_resid;
    logic [PRIME_WIDTH:0]   n_sum;
    logic [PRIME_WIDTH:0]   n_col;
    logic [SIDE_SPAN-1:0]   n_marks;
    logic                   n_par;

    assign s_we = i_cmd.do_load && i_req.prime_kind == KIND_SPLIT
                  && r_s_used != USED_W'(SPLIT_CAPACITY);
    assign i_we = i_cmd.do_load && i_req.prime_kind != KIND_SPLIT
                  && r_i_used != USED_W'(INERT_CAPACITY);

    gptsc_ram #(.WIDTH(SPLIT_W), .DEPTH(SPLIT_CAPACITY)) u_split_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (r_s_used[SPLIT_AW-1:0]),
        .i_wdata ({i_req.minus_one_root, i_req.prime_value[PRIME_WIDTH-1:0]}),
        .i_raddr (r_k[SPLIT_AW-1:0]),
        .o_rdata (s_rdata)
    );

    gptsc_ram #(.WIDTH(PRIME_WIDTH), .DEPTH(INERT_CAPACITY)) u_inert_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (r_i_used[INERT_AW-1:0]),
        .i_wdata (i_req.prime_value[PRIME_WIDTH-1:0]),
        .i_raddr (r_k[INERT_AW-1:0]),
        .o_rdata (i_rdata)
    );

    always_comb begin
        unique case (i_cmd.mod_sel)
            MOD_A:    n_src = r_a;
            MOD_B:    n_src = r_b0;
            default:  n_src = {{(COORD_WIDTH-PRIME_WIDTH){1'b0}}, r_amod}
                              * {{(COORD_WIDTH-ROOT_WIDTH){1'b0}}, r_root};
        endcase
        n_neg = (i_cmd.mod_sel != MOD_PROD) && n_src[COORD_WIDTH-1];
        n_mag = n_neg ? (~n_src + 1'b1) : n_src;
    end

    gptsc_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mod_start),
        .i_dividend (n_mag),
        .i_divisor  (r_p),
        .o_done     (rem_done),
        .o_rem      (rem_val)
    );

    always_comb begin
        n_fixed  = (r_neg && rem_val != '0) ? (r_p - rem_val) : rem_val;
        n_negres = (r_res == '0) ? '0 : (r_p - r_res);
        case (i_cmd.res_sel)
            RES_POS:  n_resid = r_res;
            RES_NEG:  n_resid = n_negres;
            default:  n_resid = '0;
        endcase
        n_sum = {1'b0, n_resid} + {1'b0, r_p} - {1'b0, r_bmod};
        n_col = (n_sum >= {1'b0, r_p}) ? (n_sum - {1'b0, r_p}) : n_sum;
        n_par = r_a[0] ^ r_b0[0];
        n_marks = r_marks;
        if (i_cmd.row_init) begin
            for (int c = 0; c < SIDE_SPAN; c++) begin
                n_marks[c] = (n_par == c[0]);
            end
        end else if (i_cmd.mark_step) begin
            n_marks[r_col[IDX_W-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_used    <= '0;
            r_i_used    <= '0;
            r_ovf       <= 1'b0;
            r_total     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cmd.do_clear) begin
                r_s_used <= '0;
                r_i_used <= '0;
                r_ovf    <= 1'b0;
            end
            if (i_cmd.do_load) begin
                if (s_we) begin
                    r_s_used <= r_s_used + 1'b1;
                end else if (i_we) begin
                    r_i_used <= r_i_used + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.tile_init) begin
                r_total <= '0;
            end else if (i_cmd.sum_step && !r_marks[r_col[IDX_W-1:0]]
                         && r_total != COUNT_MAX) begin
                r_total <= r_total + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_marks <= n_marks;
        if (i_cmd.tile_init) begin
            r_a   <= COORD_WIDTH'(i_req.tile_a_low) - COORD_WIDTH'(EDGE_MARGIN);
            r_b0  <= COORD_WIDTH'(i_req.tile_b_low) - COORD_WIDTH'(EDGE_MARGIN);
            r_row <= '0;
        end else if (i_cmd.row_inc) begin
            r_a   <= r_a + 1'b1;
            r_row <= r_row + 1'b1;
        end
        if (i_cmd.row_init || i_cmd.k_clear) begin
            r_k <= '0;
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + 1'b1;
        end
        if (i_cmd.ent_split) begin
            r_p    <= s_rdata[PRIME_WIDTH-1:0];
            r_root <= s_rdata[SPLIT_W-1:PRIME_WIDTH];
        end else if (i_cmd.ent_inert) begin
            r_p    <= i_rdata;
            r_root <= '0;
        end
        if (i_cmd.mod_start) begin
            r_sel <= i_cmd.mod_sel;
            r_neg <= n_neg;
        end
        if (rem_done) begin
            unique case (r_sel)
                MOD_A:   r_amod <= n_fixed;
                MOD_PROD: r_res <= n_fixed;
                default: r_bmod <= n_fixed;
            endcase
        end
        if (i_cmd.mark_init) begin
            r_col <= COL_W'(n_col);
        end else if (i_cmd.mark_step) begin
            r_col <= r_col + COL_W'(r_p);
        end else if (i_cmd.sum_init) begin
            r_col <= '0;
        end else if (i_cmd.sum_step) begin
            r_col <= r_col + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_rsp.survivor_count <= r_total;
            r_rsp.table_overflow <= r_ovf;
        end
    end

    always_comb begin
        o_stat.split_end = (r_k == r_s_used);
        o_stat.inert_end = (r_k == r_i_used);
        o_stat.p_zero    = (r_p == '0);
        o_stat.amod_zero = (r_amod == '0);
        o_stat.neg_same  = (n_negres == r_res);
        o_stat.mark_end  = (r_col >= COL_W'(SIDE_SPAN));
        o_stat.sum_end   = (r_col == COL_W'(SIDE_SPAN - 1));
        o_stat.row_last  = (r_row == ROW_W'(SIDE_SPAN - 1));
        o_stat.mod_done  = rem_done;
        o_stat.rsp_full  = r_rsp_valid && !i_rsp_ready;
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

/* sv/gaussian_prime_tile_sieve_count.sv */
// Gaussian prime tile sieve counter: top level joining sequencer and datapath.
// Clear and load requests are handled in idle. A count request walks 271 rows;
// per row it sets the parity marks, marks the columns of both residues of each split
// entry (one when the two residues coincide), marks the zero-residue columns of
// each inert entry whose prime divides the row, then scans for survivors. Each
// residue comes from the shared bit-serial remainder unit, which forms them in turn.
// The result waits in an output register; a new request is taken once the block is
// back in idle, and a count that finishes while an earlier result still waits holds
// until it is taken.
module gaussian_prime_tile_sieve_count (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  gptsc_pkg::t_req  i_req,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output gptsc_pkg::t_rsp  o_rsp
);
    import gptsc_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    gptsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_cmd       (i_req.cmd),
        .i_stat      (dp_stat),
        .o_req_ready (o_req_ready),
        .o_cmd       (dp_cmd)
    );

    gptsc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (dp_cmd),
        .i_rsp_ready (i_rsp_ready),
        .o_stat      (dp_stat),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

endmodule

/* sv/gptsc_checker.sv */
// Port-level checks for the tile sieve counter and their binding.
module gptsc_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic             o_req_ready,
    input  gptsc_pkg::t_req  i_req,
    input  logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    input  gptsc_pkg::t_rsp  o_rsp
);
    import gptsc_pkg::*;

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("response valid after reset");

    a_no_rsp_for_other: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready && i_req.cmd != CMD_COUNT && !o_rsp_valid)
        |=> !o_rsp_valid)
        else $error("response without count request");

    a_count_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready && i_req.cmd == CMD_COUNT) |=> !o_req_ready)
        else $error("ready during count");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !i_rsp_ready) |=> (o_rsp_valid && $stable(o_rsp)))
        else $error("stalled response changed");

endmodule

bind gaussian_prime_tile_sieve_count gptsc_checker u_checker (.*);

/* tb/tb_gaussian_prime_tile_sieve_count.sv */
// Testbench for the Gaussian prime tile sieve counter: directed table, random groups, predictor.
module tb_gaussian_prime_tile_sieve_count;
    import gptsc_pkg::*;

    localparam longint CYCLE_LIMIT = 80_000_000;
    localparam int      TAIL_CYCLES = 200;
    localparam int      HOLD_CYCLES = 400_000;
    localparam int      RANDOM_REQS = 80;

    typedef struct {
        t_req req;
        bit   fixed;
        t_rsp rsp;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_req_valid = 1'b0;
    logic o_req_ready;
    t_req i_req = '0;
    logic o_rsp_valid;
    logic i_rsp_ready = 1'b0;
    t_rsp o_rsp;

    gaussian_prime_tile_sieve_count dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // sieve tables as the block should hold them
    logic [PRIME_WIDTH-1:0] sv_split_p [SPLIT_CAPACITY];
    logic [ROOT_WIDTH-1:0]  sv_split_r [SPLIT_CAPACITY];
    logic [PRIME_WIDTH-1:0] sv_inert_p [INERT_CAPACITY];
    int   sv_split_n = 0;
    int   sv_inert_n = 0;
    logic sv_overflow = 1'b0;

    t_stim_row pending_reqs[$];
    t_rsp      expected_rsps[$];
    int        mismatches = 0;
    longint    cycles = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    bit        hold_go = 1'b0;

    function automatic longint floor_mod(longint v, longint m);
        longint r;
        r = v % m;
        if (r < 0) r += m;
        return r;
    endfunction

    function automatic void mark_residue(ref bit [SIDE_SPAN-1:0] marks, input longint sb,
                                         input longint p, input longint res);
        longint c;
        c = (res + p - floor_mod(sb, p)) % p;
        while (c < SIDE_SPAN) begin
            marks[c] = 1'b1;
            c += p;
        end
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] tile_survivors(logic [31:0] a_lo,
                                                              logic [31:0] b_lo);
        logic [31:0]          a0, b0, a;
        longint               sa, sb, p, res, neg, total;
        bit [SIDE_SPAN-1:0]   marks;
        a0 = a_lo - EDGE_MARGIN;
        b0 = b_lo - EDGE_MARGIN;
        sb = longint'(signed'(b0));
        total = 0;
        for (int row = 0; row < SIDE_SPAN; row++) begin
            a = a0 + row;
            sa = longint'(signed'(a));
            for (int c = 0; c < SIDE_SPAN; c++) marks[c] = ((a + b0 + c) & 1) == 0;
            for (int k = 0; k < sv_split_n; k++) begin
                p = sv_split_p[k];
                if (p == 0) continue;
                res = (floor_mod(sa, p) * longint'(sv_split_r[k])) % p;
                mark_residue(marks, sb, p, res);
                neg = (p - res) % p;
                if (neg != res) mark_residue(marks, sb, p, neg);
            end
            for (int k = 0; k < sv_inert_n; k++) begin
                p = sv_inert_p[k];
                if (p == 0) continue;
                if (floor_mod(sa, p) == 0) mark_residue(marks, sb, p, 0);
            end
            for (int c = 0; c < SIDE_SPAN; c++) if (!marks[c]) total++;
        end
        if (total > COUNT_MAX) total = COUNT_MAX;
        return total[COUNT_WIDTH-1:0];
    endfunction

    // applies one accepted request to the tables; returns 1 with a result for counts
    function automatic bit sieve_step(t_req r, output t_rsp rsp);
        rsp = '0;
        case (r.cmd)
            CMD_CLEAR: begin
                sv_split_n = 0;
                sv_inert_n = 0;
                sv_overflow = 1'b0;
            end
            CMD_LOAD: begin
                if (r.prime_kind == KIND_SPLIT) begin
                    if (sv_split_n >= SPLIT_CAPACITY) sv_overflow = 1'b1;
                    else begin
                        sv_split_p[sv_split_n] = r.prime_value;
                        sv_split_r[sv_split_n] = r.minus_one_root;
                        sv_split_n++;
                    end
                end else begin
                    if (sv_inert_n >= INERT_CAPACITY) sv_overflow = 1'b1;
                    else begin
                        sv_inert_p[sv_inert_n] = r.prime_value;
                        sv_inert_n++;
                    end
                end
            end
            CMD_COUNT: begin
                rsp.survivor_count = tile_survivors(r.tile_a_low, r.tile_b_low);
                rsp.table_overflow = sv_overflow;
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_stim_row row;
        t_rsp      rsp;
        if (i_rst_n && i_req_valid && o_req_ready) begin
            row = pending_reqs.pop_front();
            if (sieve_step(row.req, rsp))
                expected_rsps.insert(expected_rsps.size(), row.fixed ? row.rsp : rsp);
        end
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (expected_rsps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %0d/%0b",
                                               o_rsp.survivor_count, o_rsp.table_overflow);
            end else begin
                rsp = expected_rsps.pop_front();
                if (o_rsp.survivor_count !== rsp.survivor_count
                        || o_rsp.table_overflow !== rsp.table_overflow) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("count exp %0d got %0d, overflow exp %0b got %0b",
                                 rsp.survivor_count, o_rsp.survivor_count,
                                 rsp.table_overflow, o_rsp.table_overflow);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_go && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_go = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_rsp_ready <= 1'b0;
            end else begin
                i_rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_req(t_req r, bit fixed = 1'b0, t_rsp rsp = '0);
        t_stim_row row;
        bit        fire;
        while ($urandom_range(99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        row.req = r;
        row.fixed = fixed;
        row.rsp = rsp;
        pending_reqs.insert(pending_reqs.size(), row);
        i_req_valid <= 1'b1;
        i_req <= r;
        do begin
            @(negedge i_clk);
            fire = o_req_ready;
            @(posedge i_clk);
        end while (!fire);
    endtask

    function automatic t_req make_req(logic [1:0] cmd, logic kind, logic [13:0] p,
                                      logic [12:0] root, logic [31:0] a, logic [31:0] b);
        t_req r;
        r.cmd = cmd;
        r.prime_kind = kind;
        r.prime_value = p;
        r.minus_one_root = root;
        r.tile_a_low = a;
        r.tile_b_low = b;
        return r;
    endfunction

    initial begin
        t_stim_row table_rows[$];
        t_req      r;
        int        sent;
        int        nloads;

        table_rows = '{
            '{make_req(CMD_COUNT, KIND_SPLIT, 14'd0, 13'd0, 32'h0, 32'h0),
              1'b1, '{17'd36720, 1'b0}},
            '{make_req(CMD_COUNT, KIND_SPLIT, 14'd0, 13'd0, 32'h7FFF_FFFF, 32'h8000_0000),
              1'b1, '{17'd36721, 1'b0}},
            '{make_req(CMD_LOAD, KIND_SPLIT, 14'd5, 13'd2, 32'h0, 32'h0), 1'b0, '0},
            '{make_req(CMD_LOAD, KIND_SPLIT, 14'd13, 13'h1FFF, 32'h0, 32'h0), 1'b0, '0},
            '{make_req(CMD_LOAD, KIND_INERT, 14'd3, 13'h1FFF, 32'h0, 32'h0), 1'b0, '0},
            '{make_req(CMD_LOAD, KIND_INERT, 14'h3FFF, 13'd0, 32'h0, 32'h0), 1'b0, '0},
            '{make_req(CMD_COUNT, KIND_SPLIT, 14'd0, 13'd0, 32'h8000_0000, 32'h7FFF_FFFF),
              1'b0, '0},
            '{make_req(CMD_SPARE, KIND_INERT, 14'h3FFF, 13'h1FFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF), 1'b0, '0},
            '{make_req(CMD_COUNT, KIND_INERT, 14'h3FFF, 13'h1FFF, 32'h0, 32'h0), 1'b0, '0},
            '{make_req(CMD_CLEAR, KIND_SPLIT, 14'd0, 13'd0, 32'h0, 32'h0), 1'b0, '0},
            '{make_req(CMD_LOAD, KIND_INERT, 14'd1, 13'd0, 32'h0, 32'h0), 1'b0, '0},
            '{make_req(CMD_COUNT, KIND_SPLIT, 14'd0, 13'd0, 32'd12345, -32'sd5),
              1'b1, '{17'd0, 1'b0}},
            '{make_req(CMD_CLEAR, KIND_SPLIT, 14'd0, 13'd0, 32'h0, 32'h0), 1'b0, '0},
            '{make_req(CMD_LOAD, KIND_SPLIT, 14'd0, 13'h1FFF, 32'h0, 32'h0), 1'b0, '0},
            '{make_req(CMD_LOAD, KIND_INERT, 14'd0, 13'd0, 32'h0, 32'h0), 1'b0, '0},
            '{make_req(CMD_COUNT, KIND_SPLIT, 14'd0, 13'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
              1'b1, '{17'd36720, 1'b0}},
            '{make_req(CMD_LOAD, KIND_SPLIT, 14'd1, 13'd0, 32'h0, 32'h0), 1'b0, '0},
            '{make_req(CMD_COUNT, KIND_SPLIT, 14'd0, 13'd0, 32'h0, 32'h0),
              1'b1, '{17'd0, 1'b0}},
            '{make_req(CMD_CLEAR, KIND_SPLIT, 14'd0, 13'd0, 32'h0, 32'h0), 1'b0, '0}
        };

        send_idle_pct = 21;
        recv_idle_pct = 78;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (table_rows[i]) send_req(table_rows[i].req, table_rows[i].fixed, table_rows[i].rsp);

        send_req(make_req(CMD_CLEAR, KIND_SPLIT, 14'd0, 13'd0, 32'h0, 32'h0));
        send_req(make_req(CMD_COUNT, KIND_SPLIT, 14'd0, 13'd0, 32'h0, 32'h0),
                 1'b1, '{17'd36720, 1'b0});

        sent = 0;
        while (sent < RANDOM_REQS) begin
            if (sent >= RANDOM_REQS / 3 && sent < 2 * RANDOM_REQS / 3) begin
                send_idle_pct = 78;
                recv_idle_pct = 21;
            end else if (sent >= 2 * RANDOM_REQS / 3) begin
                if (send_idle_pct != 0) hold_go = 1'b1;
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            r = make_req(CMD_CLEAR, 1'($urandom_range(1)), 14'($urandom), 13'($urandom),
                         $urandom, $urandom);
            if ($urandom_range(9) == 0) begin
                r.cmd = CMD_SPARE;
                send_req(r);
                sent++;
                continue;
            end
            send_req(r);
            nloads = $urandom_range(2);
            for (int k = 0; k < nloads; k++) begin
                r = make_req(CMD_LOAD, 1'($urandom_range(1)), 14'($urandom), 13'($urandom),
                             $urandom, $urandom);
                if ($urandom_range(7) == 0) r.prime_value = 14'($urandom_range(1));
                else if ($urandom_range(1)) r.prime_value = 14'($urandom_range(200, 2));
                send_req(r);
            end
            r = make_req(CMD_COUNT, 1'($urandom_range(1)), 14'($urandom), 13'($urandom),
                         $urandom, $urandom);
            if ($urandom_range(4) == 0) r.tile_a_low = 32'h7FFF_FFFF - $urandom_range(20);
            if ($urandom_range(4) == 0) r.tile_b_low = 32'h8000_0000 + $urandom_range(20);
            send_req(r);
            sent += nloads + 2;
        end
        i_req_valid <= 1'b0;

        while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
